// File: rtl/dtg_pkg.sv
// shared types and constants for the depth to gray normalizer
// no dependencies
package dtg_pkg;

   localparam int DEPTH_BITS = 16;
   localparam int NUM_BITS   = DEPTH_BITS + 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [7:0]  GRAY_MAX    = 8'd255;
   localparam logic [15:0] LIMIT_RESET = 16'd600;

   localparam logic [1:0] JOB_ZERO = 2'd0;
   localparam logic [1:0] JOB_FULL = 2'd1;
   localparam logic [1:0] JOB_DIV  = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic [15:0] depth_mm;
      logic        frame_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] gray_level;
      logic       frame_end;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [DEPTH_BITS-1:0] off;
      logic [DEPTH_BITS-1:0] span;
      logic                  frame_end;
   } job_type;

endpackage

// File: rtl/depth_to_gray_normalize.sv
// top level of the two-pass depth frame contrast stretch
// depends on dtg_pkg, dtg_front, dtg_queue, dtg_back
//
//   port group   direction  handshake             word
//   req_*        in         req_valid/req_ready   req_word_type
//   rsp_*        out        rsp_valid/rsp_ready   rsp_word_type
//   csr_*        in         csr_wr_en             depth_limit, 16 bit
//
// a measure word is accepted and gives no result
// a render word clamped to 0 or 255 skips the divider in the back end, one that needs the
// divider is loaded in idle, then makes 8 quotient bits, one per cycle, then is handed off
// a two-word queue lets the front keep taking words while the divider works
// reset is synchronous; the depth limit returns to 600 and the scale is cleared
module depth_to_gray_normalize
   import dtg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic    job_push, job_pop, queue_full, queue_not_empty;
   job_type push_word, head_word;

   dtg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job_word    (push_word)
   );

   dtg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (push_word),
      .pop       (job_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_word (head_word)
   );

   dtg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_not_empty),
      .job_word  (head_word),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// File: rtl/dtg_front.sv
// front end: depth limit register, measure pass min/max tracking, render classification
// depends on dtg_pkg
module dtg_front
   import dtg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   input  logic         queue_full,
   output logic         job_push,
   output job_type      job_word
);

   logic [15:0]           depth_limit_ff, depth_limit_in;
   logic [DEPTH_BITS-1:0] running_min_ff, running_min_in;
   logic [DEPTH_BITS-1:0] running_max_ff, running_max_in;
   logic [DEPTH_BITS-1:0] scale_base_ff, scale_base_in;
   logic [DEPTH_BITS-1:0] scale_span_ff, scale_span_in;
   logic                  span_valid_ff, span_valid_in;

   logic [DEPTH_BITS-1:0] depth, lim, cur_min, cur_max, capped_max, clamped, offset;
   logic                  accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign depth     = req_word.depth_mm[DEPTH_BITS-1:0];
   assign lim       = depth_limit_ff[DEPTH_BITS-1:0];

   // measure pass
   always_comb begin
      cur_min = running_min_ff;
      cur_max = running_max_ff;
      if (depth != '0) begin
         if (depth < running_min_ff) cur_min = depth;
         if (depth > running_max_ff) cur_max = depth;
      end
      capped_max = (cur_max > lim) ? lim : cur_max;

      depth_limit_in = csr_wr_en ? csr_wr_data : depth_limit_ff;
      running_min_in = running_min_ff;
      running_max_in = running_max_ff;
      scale_base_in  = scale_base_ff;
      scale_span_in  = scale_span_ff;
      span_valid_in  = span_valid_ff;
      if (accept && !req_word.req_type) begin
         running_min_in = cur_min;
         running_max_in = cur_max;
         if (req_word.frame_last) begin
            scale_base_in = cur_min;
            if (capped_max > cur_min) begin
               scale_span_in = capped_max - cur_min;
               span_valid_in = 1'b1;
            end else begin
               scale_span_in = '0;
               span_valid_in = 1'b0;
            end
            running_min_in = lim;
            running_max_in = '0;
         end
      end
   end

   // render pass classification
   always_comb begin
      clamped = (depth > lim) ? lim : depth;
      offset  = clamped - scale_base_ff;
      job_push = accept && req_word.req_type;
      job_word.off       = offset;
      job_word.span      = scale_span_ff;
      job_word.frame_end = req_word.frame_last;
      if (depth == '0 || !span_valid_ff || scale_span_ff == '0 || clamped <= scale_base_ff)
         job_word.kind = JOB_ZERO;
      else if (offset >= scale_span_ff)
         job_word.kind = JOB_FULL;
      else
         job_word.kind = JOB_DIV;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= LIMIT_RESET;
         running_min_ff <= LIMIT_RESET[DEPTH_BITS-1:0];
         running_max_ff <= '0;
         scale_base_ff  <= '0;
         scale_span_ff  <= '0;
         span_valid_ff  <= 1'b0;
      end else begin
         depth_limit_ff <= depth_limit_in;
         running_min_ff <= running_min_in;
         running_max_ff <= running_max_in;
         scale_base_ff  <= scale_base_in;
         scale_span_ff  <= scale_span_in;
         span_valid_ff  <= span_valid_in;
      end
   end

endmodule

// File: rtl/dtg_queue.sv
// small job queue between front end and divider back end
// depends on dtg_pkg
module dtg_queue
   import dtg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_word,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head_word
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;

   assign full      = (count_ff == QUEUE_DEPTH[QPTR_BITS:0]);
   assign not_empty = (count_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/dtg_back.sv
// back end: restoring divider for 255*off/span and the result register
// depends on dtg_pkg
module dtg_back
   import dtg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         job_valid,
   input  job_type      job_word,
   output logic         job_pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_DIV  = 2'd1;
   localparam logic [1:0] BK_HOLD = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] dsr_ff, dsr_in;
   logic [2:0]          step_ff, step_in;
   logic [7:0]          quo_ff, quo_in;
   logic                fend_ff, fend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                slot_free;
   logic [NUM_BITS-1:0] off_ext, span_ext;
   logic                fits;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign off_ext   = {{(NUM_BITS-DEPTH_BITS){1'b0}}, job_word.off};
   assign span_ext  = {{(NUM_BITS-DEPTH_BITS){1'b0}}, job_word.span};
   assign fits      = (rem_ff >= dsr_ff);

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      fend_in      = fend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               fend_in = job_word.frame_end;
               rem_in  = (off_ext << 8) - off_ext;
               dsr_in  = span_ext << 7;
               step_in = 3'd7;
               quo_in  = '0;
               if (job_word.kind == JOB_DIV) begin
                  state_in = BK_DIV;
               end else begin
                  quo_in   = (job_word.kind == JOB_FULL) ? GRAY_MAX : 8'd0;
                  state_in = BK_HOLD;
               end
            end
         end
         BK_DIV: begin
            quo_in = {quo_ff[6:0], fits};
            if (fits) rem_in = rem_ff - dsr_ff;
            dsr_in = dsr_ff >> 1;
            if (step_ff == '0) state_in = BK_HOLD;
            else step_in = step_ff - 1'b1;
         end
         BK_HOLD: begin
            if (slot_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.gray_level = quo_ff;
               rsp_word_in.frame_end  = fend_ff;
               state_in               = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dsr_ff      <= dsr_in;
      step_ff     <= step_in;
      quo_ff      <= quo_in;
      fend_ff     <= fend_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
